/* rtl/lte_pkg.sv */
package lte_pkg;

    localparam int CW   = 24;
    localparam int EW   = 25;
    localparam int PW   = 50;
    localparam int AW   = 51;
    localparam int GW   = 53;
    localparam int GLW  = 26;
    localparam int GHW  = GW - GLW;
    localparam int ALW  = 26;
    localparam int AHW  = AW - ALW;
    localparam int DTW  = 80;
    localparam int PPW  = 54;
    localparam int DOTW = 110;
    localparam int DIVW = 112;
    localparam int QW   = 32;
    localparam int OW   = 32;

    typedef logic signed [EW-1:0]  edge_t;
    typedef logic signed [PW-1:0]  prod_t;
    typedef logic signed [AW-1:0]  adj_t;
    typedef logic signed [GW-1:0]  grad_t;
    typedef logic signed [DTW-1:0] det_t;
    typedef logic signed [PPW-1:0] part_t;
    typedef logic signed [DOTW-1:0] dot_t;

    typedef struct packed {
        logic [DIVW-1:0] rem;
        logic [DIVW-1:0] den;
        logic [QW-1:0]   quo;
        logic            neg;
        logic            sat;
        logic            degen;
        logic            last;
        logic [1:0]      row;
        logic [1:0]      col;
    } div_t;

endpackage

/* rtl/linear_tet_element_stiffness_unit.sv */
// Channel  | Handshake                  | Payload
// request  | in_valid / in_ready        | x0 y0 z0 .. x3 y3 z3 (signed Q8.16)
// result   | out_valid / out_ready      | row_index col_index entry_value degenerate last
//
// Each request gives 16 results, one per cycle while out_ready does not stall; the issue
// stage walks the 16 gradient pairs of one element before it takes the next request.
// Pipeline: 5 front stages, issue, 5 dot stages, 33 divider stages, output register.
// The first divider stage checks saturation; each of the other 32 resolves one quotient
// bit with one wide compare and subtract.
// Reset clears every valid bit and the issue counter. A stalled result halts the entry
// pipeline as a whole; the front stages keep filling until they back up.
module linear_tet_element_stiffness_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [lte_pkg::CW-1:0]    x0,
    input  logic signed [lte_pkg::CW-1:0]    y0,
    input  logic signed [lte_pkg::CW-1:0]    z0,
    input  logic signed [lte_pkg::CW-1:0]    x1,
    input  logic signed [lte_pkg::CW-1:0]    y1,
    input  logic signed [lte_pkg::CW-1:0]    z1,
    input  logic signed [lte_pkg::CW-1:0]    x2,
    input  logic signed [lte_pkg::CW-1:0]    y2,
    input  logic signed [lte_pkg::CW-1:0]    z2,
    input  logic signed [lte_pkg::CW-1:0]    x3,
    input  logic signed [lte_pkg::CW-1:0]    y3,
    input  logic signed [lte_pkg::CW-1:0]    z3,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       row_index,
    output logic [1:0]                       col_index,
    output logic signed [lte_pkg::OW-1:0]    entry_value,
    output logic                             degenerate,
    output logic                             last
);
    import lte_pkg::*;

    logic adv;
    logic [4:0] f_v_reg;
    logic [4:0] f_rdy;
    logic g_v_reg;
    logic g_rdy;
    logic [3:0] cnt_reg;

    edge_t e1_reg [3][3];
    prod_t p2_reg [9];
    prod_t q2_reg [9];
    edge_t e2_reg [3];
    adj_t  a3_reg [3][3];
    edge_t e3_reg [3];
    part_t dh4_reg [3];
    part_t dl4_reg [3];
    grad_t g4_reg [4][3];
    det_t  det5_reg;
    grad_t g5_reg [4][3];
    grad_t gg_reg [4][3];
    logic [DIVW-1:0] den_g_reg;
    logic [DIVW-1:0] d6_g_reg;
    logic degen_g_reg;

    logic [4:0] s_v_reg;
    grad_t gi0_reg [3];
    grad_t gj0_reg [3];
    part_t hh1_reg [3];
    part_t hl1_reg [3];
    part_t lh1_reg [3];
    part_t ll1_reg [3];
    dot_t  dd2_reg [3];
    dot_t  dot3_reg;
    logic [DIVW-1:0] num4_reg;
    logic neg4_reg;
    logic [DIVW-1:0] den_s_reg [5];
    logic [DIVW-1:0] d6_s_reg [4];
    logic degen_s_reg [5];
    logic [1:0] row_s_reg [5];
    logic [1:0] col_s_reg [5];
    logic last_s_reg [5];

    localparam int NSTEP = QW + 1;
    logic [NSTEP-1:0] d_v_reg;
    div_t d_reg [NSTEP];

    logic out_valid_reg;
    logic [1:0] row_reg;
    logic [1:0] col_reg;
    logic signed [OW-1:0] val_reg;
    logic degen_reg;
    logic last_reg;

    assign adv = !out_valid_reg || out_ready;
    assign g_rdy = !g_v_reg || (adv && cnt_reg == 4'd15);
    assign f_rdy[4] = !f_v_reg[4] || g_rdy;
    assign f_rdy[3] = !f_v_reg[3] || f_rdy[4];
    assign f_rdy[2] = !f_v_reg[2] || f_rdy[3];
    assign f_rdy[1] = !f_v_reg[1] || f_rdy[2];
    assign f_rdy[0] = !f_v_reg[0] || f_rdy[1];
    assign in_ready = f_rdy[0];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= '0;
            g_v_reg <= 1'b0;
            cnt_reg <= '0;
            s_v_reg <= '0;
            d_v_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (f_rdy[0]) f_v_reg[0] <= in_valid;
            if (f_rdy[1]) f_v_reg[1] <= f_v_reg[0];
            if (f_rdy[2]) f_v_reg[2] <= f_v_reg[1];
            if (f_rdy[3]) f_v_reg[3] <= f_v_reg[2];
            if (f_rdy[4]) f_v_reg[4] <= f_v_reg[3];
            if (g_rdy) g_v_reg <= f_v_reg[4];
            if (adv)
            begin
                if (g_v_reg) cnt_reg <= cnt_reg + 4'd1;
                s_v_reg <= {s_v_reg[3:0], g_v_reg};
                d_v_reg <= {d_v_reg[NSTEP-2:0], s_v_reg[4]};
                out_valid_reg <= d_v_reg[NSTEP-1];
            end
        end
    end

    // front datapath
    logic signed [CW-1:0] c [4][3];
    edge_t e_next [3][3];
    always_comb
    begin
        c[0][0] = x0; c[0][1] = y0; c[0][2] = z0;
        c[1][0] = x1; c[1][1] = y1; c[1][2] = z1;
        c[2][0] = x2; c[2][1] = y2; c[2][2] = z2;
        c[3][0] = x3; c[3][1] = y3; c[3][2] = z3;
        for (int d = 0; d < 3; d++)
            for (int j = 0; j < 3; j++)
                e_next[d][j] = EW'(c[j+1][d]) - EW'(c[0][d]);
    end

    logic signed [DTW-1:0] det_next;
    logic signed [DTW-1:0] det_mag;
    always_comb
    begin
        det_next = '0;
        for (int k = 0; k < 3; k++)
            det_next = det_next + (DTW'(dh4_reg[k]) <<< ALW) + DTW'(dl4_reg[k]);
        det_mag = det5_reg[DTW-1] ? -det5_reg : det5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (f_rdy[0]) e1_reg <= e_next;
        if (f_rdy[1])
        begin
            p2_reg[0] <= e1_reg[1][1] * e1_reg[2][2]; q2_reg[0] <= e1_reg[1][2] * e1_reg[2][1];
            p2_reg[1] <= e1_reg[0][2] * e1_reg[2][1]; q2_reg[1] <= e1_reg[0][1] * e1_reg[2][2];
            p2_reg[2] <= e1_reg[0][1] * e1_reg[1][2]; q2_reg[2] <= e1_reg[0][2] * e1_reg[1][1];
            p2_reg[3] <= e1_reg[1][2] * e1_reg[2][0]; q2_reg[3] <= e1_reg[1][0] * e1_reg[2][2];
            p2_reg[4] <= e1_reg[0][0] * e1_reg[2][2]; q2_reg[4] <= e1_reg[0][2] * e1_reg[2][0];
            p2_reg[5] <= e1_reg[0][2] * e1_reg[1][0]; q2_reg[5] <= e1_reg[0][0] * e1_reg[1][2];
            p2_reg[6] <= e1_reg[1][0] * e1_reg[2][1]; q2_reg[6] <= e1_reg[1][1] * e1_reg[2][0];
            p2_reg[7] <= e1_reg[0][1] * e1_reg[2][0]; q2_reg[7] <= e1_reg[0][0] * e1_reg[2][1];
            p2_reg[8] <= e1_reg[0][0] * e1_reg[1][1]; q2_reg[8] <= e1_reg[0][1] * e1_reg[1][0];
            e2_reg <= e1_reg[0];
        end
        if (f_rdy[2])
        begin
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++)
                    a3_reg[r][k] <= AW'(p2_reg[r*3+k]) - AW'(q2_reg[r*3+k]);
            e3_reg <= e2_reg;
        end
        if (f_rdy[3])
        begin
            for (int k = 0; k < 3; k++)
            begin
                dh4_reg[k] <= PPW'(e3_reg[k] * $signed(a3_reg[k][0][AW-1:ALW]));
                dl4_reg[k] <= PPW'(e3_reg[k] * $signed({1'b0, a3_reg[k][0][ALW-1:0]}));
            end
            for (int d = 0; d < 3; d++)
            begin
                g4_reg[0][d] <= -(GW'(a3_reg[0][d]) + GW'(a3_reg[1][d]) + GW'(a3_reg[2][d]));
                g4_reg[1][d] <= GW'(a3_reg[0][d]);
                g4_reg[2][d] <= GW'(a3_reg[1][d]);
                g4_reg[3][d] <= GW'(a3_reg[2][d]);
            end
        end
        if (f_rdy[4])
        begin
            det5_reg <= det_next;
            g5_reg <= g4_reg;
        end
        if (g_rdy)
        begin
            gg_reg <= g5_reg;
            d6_g_reg <= (DIVW'(det_mag) << 1) + (DIVW'(det_mag) << 2);
            den_g_reg <= (DIVW'(det_mag) << 2) + (DIVW'(det_mag) << 3);
            degen_g_reg <= det5_reg == '0;
        end
    end

    // entry datapath
    dot_t dd_next [3];
    dot_t dot_next;
    logic [DIVW-1:0] mag_next;
    always_comb
    begin
        for (int d = 0; d < 3; d++)
            dd_next[d] = (DOTW'(hh1_reg[d]) <<< (2*GLW))
                       + ((DOTW'(hl1_reg[d]) + DOTW'(lh1_reg[d])) <<< GLW)
                       + DOTW'(ll1_reg[d]);
        dot_next = dd2_reg[0] + dd2_reg[1] + dd2_reg[2];
        mag_next = dot3_reg[DOTW-1] ? DIVW'(-dot3_reg) : DIVW'(dot3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gi0_reg <= gg_reg[cnt_reg[3:2]];
            gj0_reg <= gg_reg[cnt_reg[1:0]];
            den_s_reg[0] <= den_g_reg;
            d6_s_reg[0] <= d6_g_reg;
            degen_s_reg[0] <= degen_g_reg;
            row_s_reg[0] <= cnt_reg[3:2];
            col_s_reg[0] <= cnt_reg[1:0];
            last_s_reg[0] <= cnt_reg == 4'd15;
            for (int k = 1; k < 5; k++)
            begin
                den_s_reg[k] <= den_s_reg[k-1];
                degen_s_reg[k] <= degen_s_reg[k-1];
                row_s_reg[k] <= row_s_reg[k-1];
                col_s_reg[k] <= col_s_reg[k-1];
                last_s_reg[k] <= last_s_reg[k-1];
            end
            for (int k = 1; k < 4; k++)
                d6_s_reg[k] <= d6_s_reg[k-1];
            for (int d = 0; d < 3; d++)
            begin
                hh1_reg[d] <= $signed(gi0_reg[d][GW-1:GLW]) * $signed(gj0_reg[d][GW-1:GLW]);
                hl1_reg[d] <= $signed(gi0_reg[d][GW-1:GLW])
                            * $signed({1'b0, gj0_reg[d][GLW-1:0]});
                lh1_reg[d] <= $signed({1'b0, gi0_reg[d][GLW-1:0]})
                            * $signed(gj0_reg[d][GW-1:GLW]);
                ll1_reg[d] <= $signed({1'b0, gi0_reg[d][GLW-1:0]})
                            * $signed({1'b0, gj0_reg[d][GLW-1:0]});
            end
            dd2_reg <= dd_next;
            dot3_reg <= dot_next;
            neg4_reg <= dot3_reg[DOTW-1];
            num4_reg <= (mag_next << 1) + d6_s_reg[3];
        end
    end

    // divider: saturation check, then one quotient bit per stage
    div_t d_next [NSTEP];
    always_comb
    begin
        d_next[0].rem = num4_reg;
        d_next[0].den = den_s_reg[4];
        d_next[0].quo = '0;
        d_next[0].neg = neg4_reg;
        d_next[0].sat = num4_reg >= (den_s_reg[4] << QW);
        d_next[0].degen = degen_s_reg[4];
        d_next[0].last = last_s_reg[4];
        d_next[0].row = row_s_reg[4];
        d_next[0].col = col_s_reg[4];
        for (int i = 1; i < NSTEP; i++)
        begin
            d_next[i] = d_reg[i-1];
            if (d_reg[i-1].rem >= (d_reg[i-1].den << (QW - i)))
            begin
                d_next[i].rem = d_reg[i-1].rem - (d_reg[i-1].den << (QW - i));
                d_next[i].quo[QW-i] = 1'b1;
            end
        end
    end

    div_t dl;
    logic [OW-1:0] lim;
    logic [OW-1:0] qq;
    logic signed [OW-1:0] val_next;
    always_comb
    begin
        dl = d_reg[NSTEP-1];
        lim = dl.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        qq = (dl.sat || dl.quo > lim) ? lim : dl.quo;
        val_next = dl.degen ? '0 : (dl.neg ? $signed(-qq) : $signed(qq));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_next;
            row_reg <= dl.row;
            col_reg <= dl.col;
            val_reg <= val_next;
            degen_reg <= dl.degen;
            last_reg <= dl.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_index = row_reg;
    assign col_index = col_reg;
    assign entry_value = val_reg;
    assign degenerate = degen_reg;
    assign last = last_reg;

endmodule

/* bench/linear_tet_element_stiffness_unit_tb.sv */
class stiffness_board;
    typedef logic signed [127:0] wide_t;
    typedef struct {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] val;
        logic        degen;
        logic        last;
    } entry_t;

    entry_t pending[$];
    int     errors;

    function new();
        errors = 0;
    endfunction

    function void note_request(logic signed [23:0] c [12]);
        longint p [4][3];
        longint e [3][3];
        longint a [3][3];
        longint g [4][3];
        wide_t det, dot;
        logic [127:0] mag, mdot, q, lim;
        logic neg, degen;
        entry_t x;
        for (int i = 0; i < 4; i++)
            for (int d = 0; d < 3; d++)
                p[i][d] = longint'(c[i*3+d]);
        for (int d = 0; d < 3; d++)
            for (int j = 0; j < 3; j++)
                e[d][j] = p[j+1][d] - p[0][d];
        a[0][0] = e[1][1]*e[2][2] - e[1][2]*e[2][1];
        a[0][1] = e[0][2]*e[2][1] - e[0][1]*e[2][2];
        a[0][2] = e[0][1]*e[1][2] - e[0][2]*e[1][1];
        a[1][0] = e[1][2]*e[2][0] - e[1][0]*e[2][2];
        a[1][1] = e[0][0]*e[2][2] - e[0][2]*e[2][0];
        a[1][2] = e[0][2]*e[1][0] - e[0][0]*e[1][2];
        a[2][0] = e[1][0]*e[2][1] - e[1][1]*e[2][0];
        a[2][1] = e[0][1]*e[2][0] - e[0][0]*e[2][1];
        a[2][2] = e[0][0]*e[1][1] - e[0][1]*e[1][0];
        for (int d = 0; d < 3; d++)
        begin
            g[0][d] = -(a[0][d] + a[1][d] + a[2][d]);
            g[1][d] = a[0][d];
            g[2][d] = a[1][d];
            g[3][d] = a[2][d];
        end
        det = wide_t'(e[0][0])*wide_t'(a[0][0]) + wide_t'(e[0][1])*wide_t'(a[1][0])
            + wide_t'(e[0][2])*wide_t'(a[2][0]);
        degen = (det == 0);
        mag = (det < 0) ? -det : det;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
            begin
                x.row = 2'(i);
                x.col = 2'(j);
                x.degen = degen;
                x.last = (i == 3 && j == 3);
                x.val = '0;
                if (!degen)
                begin
                    dot = wide_t'(g[i][0])*wide_t'(g[j][0]) + wide_t'(g[i][1])*wide_t'(g[j][1])
                        + wide_t'(g[i][2])*wide_t'(g[j][2]);
                    neg = dot < 0;
                    mdot = neg ? -dot : dot;
                    q = (2*mdot + 6*mag) / (12*mag);
                    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
                    if (q > lim)
                        q = lim;
                    x.val = neg ? -q[31:0] : q[31:0];
                end
                pending.push_back(x);
            end
    endfunction

    function void check_result(logic [1:0] row, logic [1:0] col, logic [31:0] val,
                               logic degen, logic last);
        entry_t x;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result row %0d col %0d value %h", $time, row, col, val);
            errors++;
            return;
        end
        x = pending.pop_front();
        if (row !== x.row || col !== x.col || val !== x.val || degen !== x.degen
            || last !== x.last)
        begin
            $display("%0t: mismatch expected row %0d col %0d value %h degen %b last %b",
                     $time, x.row, x.col, x.val, x.degen, x.last);
            $display("%0t:          actual   row %0d col %0d value %h degen %b last %b",
                     $time, row, col, val, degen, last);
            errors++;
        end
    endfunction
endclass

module linear_tet_element_stiffness_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
    logic signed [23:0] x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3;
    logic [1:0] row_index, col_index;
    logic signed [31:0] entry_value;
    logic degenerate, last;

    stiffness_board board = new();
    int idle_cycles = 0;

    linear_tet_element_stiffness_unit u_top (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic send_request(logic signed [23:0] c [12]);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        {x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3} <=
            {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]};
        in_valid <= 1;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(c);
        @(negedge clk);
    endtask

    task automatic make_tet(int kind, output logic signed [23:0] c [12]);
        for (int k = 0; k < 12; k++)
            c[k] = (kind == 1) ? 24'($signed($urandom_range(0, 262143)) - 131072)
                               : 24'($urandom);
        if (kind == 2)
            for (int k = 0; k < 3; k++)
                c[9+k] = c[3+k];
        if (kind == 3)
        begin
            for (int k = 0; k < 3; k++)
                c[9+k] = c[3+k];
            c[11] = c[11] + 24'sd1;
        end
    endtask

    initial
    begin
        logic signed [23:0] c [12];
        in_valid = 0;
        out_ready = 0;
        {x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3} = '0;
        rst_n = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        c = '{default: 0};
        send_request(c);
        c = '{0, 0, 0, 24'h010000, 0, 0, 0, 24'h010000, 0, 0, 0, 24'h010000};
        send_request(c);
        c = '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
              24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh7FFFFF};
        send_request(c);
        c = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF,
              24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000};
        send_request(c);
        c = '{0, 0, 0, 24'sh7FFFFF, 0, 0, 0, 24'sh7FFFFF, 0, 0, 0, 1};
        send_request(c);
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_request(c);
        for (int k = 0; k < 12; k++)
        begin
            make_tet(k % 4, c);
            send_request(c);
        end

        for (int n = 0; n < 500; n++)
        begin
            int r;
            r = $urandom_range(0, 9);
            make_tet(r < 4 ? 0 : r < 7 ? 1 : r < 8 ? 2 : 3, c);
            send_request(c);
        end
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            board.check_result(row_index, col_index, entry_value, degenerate, last);
        if ((out_valid && out_ready) || (in_valid && in_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 3000)
        begin
            $display("%0t: watchdog expired", $time);
            $display("Simulation FAILED");
            $finish;
        end
    end
endmodule
